// File: src/wgds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wgds_pkg
// shared constants, codes and control types of the dependency scoreboard
// ----------------------------------------------------------------------------
package wgds_pkg;

    localparam int N_NODES    = 64;
    localparam int IDX_W      = $clog2(N_NODES);
    localparam int TOTAL_W    = $clog2(N_NODES + 1);
    localparam int N_WAITS    = 8;
    localparam int WSLOT_W    = $clog2(N_WAITS);
    localparam int WCNT_W     = $clog2(N_WAITS + 1);

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_ADD_NODE = 3'd1,
        OP_ADD_DEP  = 3'd2,
        OP_SET      = 3'd3,
        OP_REFRESH  = 3'd4,
        OP_QUERY    = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        NS_PENDING = 3'd0,
        NS_READY   = 3'd1,
        NS_RUNNING = 3'd2,
        NS_DONE    = 3'd3,
        NS_FAILED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_TABLE     = 2'd1,
        ERR_LIST      = 2'd2,
        ERR_UNKNOWN   = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_REPORT,
        S_RING_LOAD,
        S_RING,
        S_RESOLVE,
        S_COUNT
    } fsm_t;

    // broadcast controls
    typedef struct packed {
        logic load_node;
        logic add_dep;
        logic set_state;
        logic ring_load;
        logic ring_shift;
        logic resolve;
        logic flag_shift;
    } cell_ctrl_t;

endpackage : wgds_pkg
`default_nettype wire

// File: src/work_graph_dependency_scoreboard.sv
`default_nettype none
// ----------------------------------------------------------------------------
// work_graph_dependency_scoreboard
// node table with dependency lists, executor state updates and refresh
// ----------------------------------------------------------------------------
// A command transfers at a rising edge with start high and busy low; its one
// result appears on the result ports for exactly one cycle with done high,
// and the receiver cannot stall it. Clear, unknown operation and error answers
// are given from the execute state; add node, add dependency, set state and
// query pass through the report state first. Refresh loads the ring, then the
// done flags of all nodes circulate once around the ring of node cells, one
// position a cycle, then the cells resolve and the newly ready flags shift out
// of the chain one a cycle into the counter. Busy stays high for the whole command.
module work_graph_dependency_scoreboard
    import wgds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [2:0]  operation,
    input  wire logic [7:0]  target_id,
    input  wire logic [7:0]  prereq_id,
    input  wire logic [2:0]  new_state,
    input  wire logic [2:0]  op_kind,
    input  wire logic [31:0] priority_in,
    input  wire logic [63:0] deadline_in,
    input  wire logic [31:0] devices_in,
    output logic             busy,
    output logic             done,
    output logic [7:0]       result_id,
    output logic [2:0]       result_state,
    output logic [2:0]       result_kind,
    output logic [31:0]      result_priority,
    output logic [63:0]      result_deadline,
    output logic [31:0]      result_devices,
    output logic [1:0]       error_code,
    output logic [6:0]       newly_ready
);

    fsm_t                state_reg, state_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [6:0]          count_reg, count_next;
    logic                done_reg, done_next;

    // captured command
    logic [2:0]  op_reg;
    logic [7:0]  target_reg;
    logic [7:0]  dep_reg;
    logic [2:0]  nstate_reg;
    logic [2:0]  kind_reg;
    logic [31:0] pri_reg;
    logic [63:0] dl_reg;
    logic [31:0] dev_reg;

    // result registers
    logic [7:0]  rid_reg, rid_next;
    logic [2:0]  rstate_reg, rstate_next;
    logic [2:0]  rkind_reg, rkind_next;
    logic [31:0] rpri_reg, rpri_next;
    logic [63:0] rdl_reg, rdl_next;
    logic [31:0] rdev_reg, rdev_next;
    logic [1:0]  err_reg, err_next;
    logic [6:0]  ready_reg, ready_next;

    cell_ctrl_t          ctrl;
    logic [IDX_W-1:0]    sel_idx;
    logic [IDX_W-1:0]    rd_idx;
    logic [IDX_W-1:0]    target_idx;
    logic [7:0]          target_m1;
    logic                target_unknown;

    // per-cell outputs
    logic [2:0]          c_status [N_NODES];
    logic [2:0]          c_kind   [N_NODES];
    logic [31:0]         c_pri    [N_NODES];
    logic [63:0]         c_dl     [N_NODES];
    logic [31:0]         c_dev    [N_NODES];
    logic [WCNT_W-1:0]   c_wcnt   [N_NODES];
    logic                c_rdone  [N_NODES];
    logic [7:0]          c_rid    [N_NODES];
    logic                c_flag   [N_NODES];

    // readout of the addressed cell
    logic [2:0]          rd_status;
    logic [2:0]          rd_kind;
    logic [31:0]         rd_pri;
    logic [63:0]         rd_dl;
    logic [31:0]         rd_dev;
    logic [WCNT_W-1:0]   rd_wcnt;

    // ------------------------------------------------------------------
    // row of node cells; ring and flag chain run toward lower indexes
    // ------------------------------------------------------------------
    for (genvar k = 0; k < N_NODES; k++)
    begin : g_cell
        localparam int NXT = (k + 1) % N_NODES;
        logic flag_in;

        if (k == N_NODES - 1)
        begin : g_last
            assign flag_in = 1'b0;
        end
        else
        begin : g_mid
            assign flag_in = c_flag[k + 1];
        end

        wgds_cell u_cell
        (
            .clk           (clk),
            .ctrl          (ctrl),
            .sel           (sel_idx == IDX_W'(k)),
            .known         (TOTAL_W'(k) < total_reg),
            .cell_id       (8'(k + 1)),
            .wr_state      (nstate_reg),
            .wr_kind       (kind_reg),
            .wr_priority   (pri_reg),
            .wr_deadline   (dl_reg),
            .wr_devices    (dev_reg),
            .wr_dep        (dep_reg),
            .ring_done_in  (c_rdone[NXT]),
            .ring_id_in    (c_rid[NXT]),
            .flag_in       (flag_in),
            .status        (c_status[k]),
            .kind          (c_kind[k]),
            .priority_q    (c_pri[k]),
            .deadline      (c_dl[k]),
            .devices       (c_dev[k]),
            .wait_count    (c_wcnt[k]),
            .ring_done_out (c_rdone[k]),
            .ring_id_out   (c_rid[k]),
            .flag_out      (c_flag[k])
        );
    end

    // target decode: id 0 and ids past the node count are unknown
    assign target_m1      = target_reg - 8'd1;
    assign target_idx     = target_m1[IDX_W-1:0];
    assign target_unknown = (target_reg == 8'd0) || (target_reg > 8'(total_reg));

    // add node writes the next free slot, everything else the target
    assign sel_idx = (op_t'(op_reg) == OP_ADD_NODE) ? total_reg[IDX_W-1:0] : target_idx;
    assign rd_idx  = (state_reg == S_REPORT) ? idx_reg : target_idx;

    always_comb
    begin
        rd_status = '0;
        rd_kind   = '0;
        rd_pri    = '0;
        rd_dl     = '0;
        rd_dev    = '0;
        rd_wcnt   = '0;
        for (int k = 0; k < N_NODES; k++)
        begin
            if (rd_idx == IDX_W'(k))
            begin
                rd_status = rd_status | c_status[k];
                rd_kind   = rd_kind | c_kind[k];
                rd_pri    = rd_pri | c_pri[k];
                rd_dl     = rd_dl | c_dl[k];
                rd_dev    = rd_dev | c_dev[k];
                rd_wcnt   = rd_wcnt | c_wcnt[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // state register and control
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        count_reg  <= count_next;
        rid_reg    <= rid_next;
        rstate_reg <= rstate_next;
        rkind_reg  <= rkind_next;
        rpri_reg   <= rpri_next;
        rdl_reg    <= rdl_next;
        rdev_reg   <= rdev_next;
        err_reg    <= err_next;
        ready_reg  <= ready_next;
        if (start && !busy)
        begin
            op_reg     <= operation;
            target_reg <= target_id;
            dep_reg    <= prereq_id;
            nstate_reg <= new_state;
            kind_reg   <= op_kind;
            pri_reg    <= priority_in;
            dl_reg     <= deadline_in;
            dev_reg    <= devices_in;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        rid_next    = rid_reg;
        rstate_next = rstate_reg;
        rkind_next  = rkind_reg;
        rpri_next   = rpri_reg;
        rdl_next    = rdl_reg;
        rdev_next   = rdev_reg;
        err_next    = err_reg;
        ready_next  = ready_reg;
        ctrl        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // answers without a node are all zero but for the error code
                rid_next    = '0;
                rstate_next = '0;
                rkind_next  = '0;
                rpri_next   = '0;
                rdl_next    = '0;
                rdev_next   = '0;
                err_next    = ERR_OK;
                ready_next  = '0;
                idx_next    = target_idx;
                done_next   = 1'b1;
                state_next  = S_IDLE;
                case (op_reg)
                    OP_CLEAR:
                    begin
                        total_next = '0;
                    end
                    OP_ADD_NODE:
                    begin
                        if (total_reg >= TOTAL_W'(N_NODES))
                        begin
                            err_next = ERR_TABLE;
                        end
                        else
                        begin
                            ctrl.load_node = 1'b1;
                            idx_next       = total_reg[IDX_W-1:0];
                            total_next     = total_reg + TOTAL_W'(1);
                            done_next      = 1'b0;
                            state_next     = S_REPORT;
                        end
                    end
                    OP_ADD_DEP:
                    begin
                        if (target_unknown)
                        begin
                            err_next = ERR_UNKNOWN;
                        end
                        else if (rd_wcnt >= WCNT_W'(N_WAITS))
                        begin
                            err_next = ERR_LIST;
                        end
                        else
                        begin
                            ctrl.add_dep = 1'b1;
                            done_next    = 1'b0;
                            state_next   = S_REPORT;
                        end
                    end
                    OP_SET:
                    begin
                        if (target_unknown)
                        begin
                            err_next = ERR_UNKNOWN;
                        end
                        else
                        begin
                            // codes above failed leave the node as it is
                            ctrl.set_state = (nstate_reg <= NS_FAILED);
                            done_next      = 1'b0;
                            state_next     = S_REPORT;
                        end
                    end
                    OP_REFRESH:
                    begin
                        done_next  = 1'b0;
                        state_next = S_RING_LOAD;
                    end
                    OP_QUERY:
                    begin
                        if (target_unknown)
                        begin
                            err_next = ERR_UNKNOWN;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            state_next = S_REPORT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_REPORT:
            begin
                rid_next    = 8'(idx_reg) + 8'd1;
                rstate_next = rd_status;
                rkind_next  = rd_kind;
                rpri_next   = rd_pri;
                rdl_next    = rd_dl;
                rdev_next   = rd_dev;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            S_RING_LOAD:
            begin
                ctrl.ring_load = 1'b1;
                cnt_next       = '0;
                state_next     = S_RING;
            end

            S_RING:
            begin
                // every cell sees every id once
                ctrl.ring_shift = 1'b1;
                cnt_next        = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(N_NODES - 1))
                begin
                    state_next = S_RESOLVE;
                end
            end

            S_RESOLVE:
            begin
                ctrl.resolve = 1'b1;
                cnt_next     = '0;
                count_next   = '0;
                state_next   = S_COUNT;
            end

            S_COUNT:
            begin
                ctrl.flag_shift = 1'b1;
                cnt_next        = cnt_reg + IDX_W'(1);
                count_next      = count_reg + 7'(c_flag[0]);
                if (cnt_reg == IDX_W'(N_NODES - 1))
                begin
                    ready_next = count_reg + 7'(c_flag[0]);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign result_id       = rid_reg;
    assign result_state    = rstate_reg;
    assign result_kind     = rkind_reg;
    assign result_priority = rpri_reg;
    assign result_deadline = rdl_reg;
    assign result_devices  = rdev_reg;
    assign error_code      = err_reg;
    assign newly_ready     = ready_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg != S_IDLE))
        else $error("result strobe without a command in flight");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TOTAL_W'(N_NODES))
        else $error("node count beyond table size");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    a_err_no_node: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (error_code != ERR_OK)) |-> (result_id == 8'd0))
        else $error("error answer reports a node");

endmodule : work_graph_dependency_scoreboard
`default_nettype wire

// File: src/wgds_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wgds_cell
// one node slot: node fields, wait list, ring slot and count flag
// ----------------------------------------------------------------------------
module wgds_cell
    import wgds_pkg::*;
(
    input  wire logic          clk,
    input  wire cell_ctrl_t    ctrl,
    input  wire logic          sel,
    input  wire logic          known,
    input  wire logic [7:0]    cell_id,
    input  wire logic [2:0]    wr_state,
    input  wire logic [2:0]    wr_kind,
    input  wire logic [31:0]   wr_priority,
    input  wire logic [63:0]   wr_deadline,
    input  wire logic [31:0]   wr_devices,
    input  wire logic [7:0]    wr_dep,
    input  wire logic          ring_done_in,
    input  wire logic [7:0]    ring_id_in,
    input  wire logic          flag_in,
    output logic [2:0]         status,
    output logic [2:0]         kind,
    output logic [31:0]        priority_q,
    output logic [63:0]        deadline,
    output logic [31:0]        devices,
    output logic [WCNT_W-1:0]  wait_count,
    output logic               ring_done_out,
    output logic [7:0]         ring_id_out,
    output logic               flag_out
);

    logic [2:0]         status_reg;
    logic [2:0]         kind_reg;
    logic [31:0]        priority_reg;
    logic [63:0]        deadline_reg;
    logic [31:0]        devices_reg;
    logic [WCNT_W-1:0]  wcnt_reg;
    logic [7:0]         wlist_reg [N_WAITS];
    logic [N_WAITS-1:0] sat_reg;
    logic               rdone_reg;
    logic [7:0]         rid_reg;
    logic               flag_reg;
    logic [N_WAITS-1:0] used;
    logic               eligible;

    always_comb
    begin
        for (int j = 0; j < N_WAITS; j++)
        begin
            used[j] = (WCNT_W'(j) < wcnt_reg);
        end
        eligible = known && (status_reg == NS_PENDING) && (&(sat_reg | ~used));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_node && sel)
        begin
            status_reg   <= NS_PENDING;
            kind_reg     <= wr_kind;
            priority_reg <= wr_priority;
            deadline_reg <= wr_deadline;
            devices_reg  <= wr_devices;
            wcnt_reg     <= '0;
        end
        if (ctrl.add_dep && sel)
        begin
            wlist_reg[wcnt_reg[WSLOT_W-1:0]] <= wr_dep;
            wcnt_reg <= wcnt_reg + WCNT_W'(1);
        end
        if (ctrl.set_state && sel)
        begin
            status_reg <= wr_state;
        end
        if (ctrl.ring_load)
        begin
            rdone_reg <= known && (status_reg == NS_DONE);
            rid_reg   <= cell_id;
            sat_reg   <= '0;
        end
        if (ctrl.ring_shift)
        begin
            // match the id passing through this slot, then pass it on
            for (int j = 0; j < N_WAITS; j++)
            begin
                if (rdone_reg && (rid_reg == wlist_reg[j]))
                begin
                    sat_reg[j] <= 1'b1;
                end
            end
            rdone_reg <= ring_done_in;
            rid_reg   <= ring_id_in;
        end
        if (ctrl.resolve)
        begin
            if (eligible)
            begin
                status_reg <= NS_READY;
            end
            flag_reg <= eligible;
        end
        if (ctrl.flag_shift)
        begin
            flag_reg <= flag_in;
        end
    end

    assign status        = status_reg;
    assign kind          = kind_reg;
    assign priority_q    = priority_reg;
    assign deadline      = deadline_reg;
    assign devices       = devices_reg;
    assign wait_count    = wcnt_reg;
    assign ring_done_out = rdone_reg;
    assign ring_id_out   = rid_reg;
    assign flag_out      = flag_reg;

endmodule : wgds_cell
`default_nettype wire
